### hw/rtl/bsc_pkg.sv
// Shared types and codes of the banned substring checker.
package bsc_pkg;

    // Width of the reported pattern count.
    localparam int COUNT_W = 5;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // Result status codes.
    localparam logic [2:0] ST_LEGAL    = 3'd0;
    localparam logic [2:0] ST_ILLEGAL  = 3'd1;
    localparam logic [2:0] ST_STORED   = 3'd2;
    localparam logic [2:0] ST_REJECTED = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic shift;
        logic scan_issue;
        logic load_rd;
        logic load_wr;
        logic finish;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  last;
        logic  scan_more;
        logic  rd_pending;
        logic  load_write_ok;
        logic  out_free;
    } t_stat;

endpackage

### hw/rtl/bsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bsc_datapath.sv
// Datapath: text window, pattern RAM, table counters, match logic and result register.
module bsc_datapath #(
    parameter int NUM_TABLES   = 2,
    parameter int NUM_PATTERNS = 16,
    parameter int MAX_LEN      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsc_pkg::t_cmd               i_cmd,
    output bsc_pkg::t_stat              o_stat,
    input  logic [1:0]                  i_kind,
    input  logic                        i_table_sel,
    input  logic [7:0]                  i_data,
    input  logic                        i_last,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [2:0]                  o_status,
    output logic [bsc_pkg::COUNT_W-1:0] o_stored_count
);

    import bsc_pkg::*;

    localparam int DEPTH = NUM_TABLES * NUM_PATTERNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CW    = $clog2(NUM_PATTERNS + 1);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int BW    = 8 * MAX_LEN;
    localparam int RW    = BW + LW;

    // Captured request.
    t_kind           r_kind;
    logic [TW-1:0]   r_t;
    logic [7:0]      r_data;
    logic            r_last;

    // Control state.
    logic [CW-1:0]   r_fill [NUM_TABLES];
    logic [LW-1:0]   r_pos;
    logic            r_ovf;
    logic [LW-1:0]   r_win_fill;
    logic            r_hit;
    logic [CW-1:0]   r_scan_idx;
    logic            r_rd_vld;
    logic            r_out_valid;

    // Text window, newest byte at index 0.
    logic [7:0]      r_window [MAX_LEN];

    // Result register.
    logic [2:0]         r_status;
    logic [COUNT_W-1:0] r_count;

    logic [CW-1:0]   fill_cur;
    logic            table_full;
    logic            ovf_next;
    logic [AW-1:0]   base_addr;
    logic [AW-1:0]   scan_addr;
    logic [AW-1:0]   load_addr;
    logic [RW-1:0]   ram_rdata;
    logic [RW-1:0]   merged;
    logic [LW-1:0]   row_len;
    logic [LW-1:0]   shift_amt;
    logic [BW-1:0]   win_rev;
    logic [BW-1:0]   win_sh;
    logic [MAX_LEN-1:0] byte_ok;
    logic            row_match;
    logic [2:0]      n_status;
    logic [COUNT_W-1:0] n_count;

    assign fill_cur   = r_fill[r_t];
    assign table_full = (fill_cur >= CW'(NUM_PATTERNS));
    assign ovf_next   = r_ovf || (r_pos == LW'(MAX_LEN));

    // Row address of a table slot.
    assign base_addr = AW'(r_t) * AW'(NUM_PATTERNS);
    assign scan_addr = base_addr + AW'(r_scan_idx);
    assign load_addr = base_addr + AW'(fill_cur);

    // Pattern RAM: one row per slot, bytes below and length on top.
    bsc_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (load_addr),
        .i_wdata (merged),
        .i_re    (i_cmd.scan_issue || i_cmd.load_rd),
        .i_raddr (i_cmd.scan_issue ? scan_addr : load_addr),
        .o_rdata (ram_rdata)
    );

    // Insert the pattern byte into the row read back; set the length on the last byte.
    always_comb begin
        merged = ram_rdata;
        for (int j = 0; j < MAX_LEN; j++) begin
            if (LW'(j) == r_pos) begin
                merged[8*j +: 8] = r_data;
            end
        end
        if (r_last) begin
            merged[RW-1 -: LW] = LW'(r_pos + 1'b1);
        end
    end

    // Compare a stored row against the text bytes ending at the newest byte.
    // Pattern byte j lines up with the window byte len-1-j.
    always_comb begin
        row_len   = ram_rdata[RW-1 -: LW];
        shift_amt = LW'(MAX_LEN) - row_len;
        for (int k = 0; k < MAX_LEN; k++) begin
            win_rev[8*(MAX_LEN-1-k) +: 8] = r_window[k];
        end
        win_sh = win_rev >> {shift_amt, 3'b000};
        for (int j = 0; j < MAX_LEN; j++) begin
            byte_ok[j] = (LW'(j) >= row_len) || (ram_rdata[8*j +: 8] == win_sh[8*j +: 8]);
        end
        row_match = (row_len != '0) && (row_len <= LW'(MAX_LEN))
                    && (row_len <= r_win_fill) && (&byte_ok);
    end

    // Result fields for the request being finished.
    always_comb begin
        n_status = ST_CLEARED;
        n_count  = '0;
        case (r_kind)
            KIND_TEXT: begin
                n_status = r_hit ? ST_ILLEGAL : ST_LEGAL;
                n_count  = COUNT_W'(fill_cur);
            end
            KIND_LOAD: begin
                if (ovf_next || table_full) begin
                    n_status = ST_REJECTED;
                    n_count  = COUNT_W'(fill_cur);
                end else begin
                    n_status = ST_STORED;
                    n_count  = COUNT_W'(fill_cur + 1'b1);
                end
            end
            default: begin
                n_status = ST_CLEARED;
                n_count  = '0;
            end
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_t    <= (NUM_TABLES == 1) ? '0 : TW'(i_table_sel);
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    // Text window shift.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_window[0] <= r_data;
            for (int k = 1; k < MAX_LEN; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

    // Scan counter and read tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.capture) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    // Table counters, load progress, window fill and hit flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_fill[t] <= '0;
            end
            r_pos      <= '0;
            r_ovf      <= 1'b0;
            r_win_fill <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (i_cmd.shift && (r_win_fill != LW'(MAX_LEN))) begin
                r_win_fill <= r_win_fill + 1'b1;
            end
            if (r_rd_vld && row_match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.finish) begin
                case (r_kind)
                    KIND_TEXT: begin
                        if (r_last) begin
                            r_win_fill <= '0;
                            r_hit      <= 1'b0;
                        end
                    end
                    KIND_LOAD: begin
                        if (r_last) begin
                            if (!ovf_next && !table_full) begin
                                r_fill[r_t] <= fill_cur + 1'b1;
                            end
                            r_pos <= '0;
                            r_ovf <= 1'b0;
                        end else begin
                            r_ovf <= ovf_next;
                            if (r_pos != LW'(MAX_LEN)) begin
                                r_pos <= r_pos + 1'b1;
                            end
                        end
                    end
                    KIND_CLEAR: begin
                        r_fill[r_t] <= '0;
                        r_pos       <= '0;
                        r_ovf       <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_stored_count = r_count;

    // Status toward the controller.
    assign o_stat.kind          = r_kind;
    assign o_stat.last          = r_last;
    assign o_stat.scan_more     = (r_scan_idx < fill_cur);
    assign o_stat.rd_pending    = r_rd_vld;
    assign o_stat.load_write_ok = (r_pos != LW'(MAX_LEN)) && !table_full;
    assign o_stat.out_free      = !r_out_valid || i_out_ready;

endmodule

### hw/rtl/bsc_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module bsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bsc_pkg::t_stat  i_stat,
    output bsc_pkg::t_cmd   o_cmd
);

    import bsc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_LREAD  = 6'b001000,
        S_LWRITE = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   need_out;

    // A result is produced by the last byte of a text or pattern, and by a clear.
    always_comb begin
        case (i_stat.kind)
            KIND_TEXT:  need_out = i_stat.last;
            KIND_LOAD:  need_out = i_stat.last;
            KIND_CLEAR: need_out = 1'b1;
            default:    need_out = 1'b0;
        endcase
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_TEXT: begin
                        o_cmd.shift = 1'b1;
                        n_state     = S_SCAN;
                    end
                    KIND_LOAD: begin
                        n_state = i_stat.load_write_ok ? S_LREAD : S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                // One row read per stored pattern; each compare is made in the cycle after its read.
                o_cmd.scan_issue = i_stat.scan_more;
                if (!i_stat.scan_more && !i_stat.rd_pending) begin
                    n_state = S_FINISH;
                end
            end
            S_LREAD: begin
                o_cmd.load_rd = 1'b1;
                n_state       = S_LWRITE;
            end
            S_LWRITE: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!need_out || i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.emit   = need_out;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hw/rtl/banned_substring_checker_top.sv
// Top level of the banned substring checker.
// The block holds NUM_TABLES tables of up to NUM_PATTERNS banned byte patterns of 1 to
// MAX_LEN bytes each, stored one pattern per row in a single RAM. Requests arrive one
// at a time: a text byte, a pattern byte to load, or a clear of the selected table.
// A text byte is compared with each pattern held in the selected table: the pattern
// RAM has one read port, each stored pattern is read as one row, and the compare of
// the last row read is made in the cycle after its read. A pattern byte is handled
// by a read, merge and write back of its row; a clear, a byte beyond the length limit
// or a byte for a full table goes straight to the finish state. A result appears on
// the last byte of a text or pattern and on every clear; it sits in an output register,
// so the next request is taken while it waits, and the block stalls only when a second
// result is ready before the first has been taken. No clearing pass runs after reset.
module banned_substring_checker_top #(
    parameter int NUM_TABLES   = 2,
    parameter int NUM_PATTERNS = 16,
    parameter int MAX_LEN      = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_kind,
    input  logic                        i_table_sel,
    input  logic [7:0]                  i_data,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_status,
    output logic [bsc_pkg::COUNT_W-1:0] o_stored_count
);

    import bsc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Request sequencing.
    bsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Storage, matching and result register.
    bsc_datapath #(
        .NUM_TABLES   (NUM_TABLES),
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_LEN      (MAX_LEN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_table_sel    (i_table_sel),
        .i_data         (i_data),
        .i_last         (i_last),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_stored_count (o_stored_count)
    );

    // A cleared table always reports an empty count.
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_CLEARED)) |-> (o_stored_count == '0))
        else $error("clear result with nonzero count");

    // Only defined status codes are ever presented.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_CLEARED))
        else $error("undefined status code");

    // A request is worked on before the next is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while another is in progress");

    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result lost");

endmodule
